[rtl/core/rgb_led_effect_generator_macros.svh]
// Assertion macros used by the checker file.
`ifndef RGB_LED_EFFECT_GENERATOR_MACROS_SVH
`define RGB_LED_EFFECT_GENERATOR_MACROS_SVH

// Check cons in the same cycle as ante.
`define RGBFX_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante.
`define RGBFX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/rgbfx_pkg.sv]
package rgbfx_pkg;

	localparam int unsigned SINE_TABLE_DEPTH   = 256;
	localparam int unsigned HUE_UNITS_PER_TURN = 900;

	localparam int unsigned CH_W      = 8;
	localparam int unsigned COLOUR_W  = 3 * CH_W;
	localparam int unsigned REG_W     = 8;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned Q15_W     = 16;
	localparam int unsigned STEP_W    = 7;
	localparam int unsigned WAIT_W    = 8;
	localparam int unsigned HUE_W     = $clog2(HUE_UNITS_PER_TURN + 1);
	localparam int unsigned HUE_SUM_W = HUE_W + 1;
	localparam int unsigned H6_W      = $clog2(6 * HUE_UNITS_PER_TURN + 1);
	localparam int unsigned T_W       = 24;

	localparam int unsigned MUL_A_W = 32;
	localparam int unsigned MUL_B_W = 16;
	localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int unsigned SCALE_SHIFT = 30;

	// x / (HUE_UNITS_PER_TURN * 32768) as ((x >> 17) * HUE_RECIP) >> 24
	localparam int unsigned HUE_ODD         = HUE_UNITS_PER_TURN / 4;
	localparam int unsigned HUE_PRE_SHIFT   = 15 + 2;
	localparam int unsigned HUE_RECIP_SHIFT = 24;
	localparam int unsigned HUE_RECIP       =
		((1 << HUE_RECIP_SHIFT) + HUE_ODD - 1) / HUE_ODD;

	localparam logic [Q15_W-1:0] Q15_ONE = Q15_W'(32768);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASE_RED   = 3'd0,
		REG_BASE_GREEN = 3'd1,
		REG_BASE_BLUE  = 3'd2,
		REG_MODE       = 3'd3,
		REG_SPEED      = 3'd4,
		REG_BRIGHTNESS = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		FX_SOLID = 2'd0,
		FX_PULSE = 2'd1,
		FX_WHEEL = 2'd2,
		FX_DARK  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_RISE  = 2'd1,
		PH_FALL  = 2'd2,
		PH_PAUSE = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		ACT_NONE,
		ACT_BLACK,
		ACT_SCALE,
		ACT_HUE
	} act_t;

	typedef enum logic [1:0] {
		T_IDLE,
		T_CALC,
		T_OUT
	} top_state_t;

	typedef enum logic {
		CK_SCALE,
		CK_HUE
	} calc_kind_t;

	typedef enum logic [2:0] {
		C_IDLE,
		C_SCALE_P,
		C_SCALE_CH,
		C_HUE_SECT,
		C_HUE_MUL,
		C_HUE_DIV,
		C_DONE
	} calc_state_t;

	typedef struct packed {
		logic       start;
		calc_kind_t kind;
	} calc_req_t;

	typedef struct packed {
		logic                done;
		logic [COLOUR_W-1:0] colour;
	} calc_rsp_t;

	localparam logic [Q15_W-1:0] BRIGHT_Q15 [4] = '{
		Q15_W'(4915), Q15_W'(10813), Q15_W'(21627), Q15_W'(32768)
	};

	localparam int unsigned RAMP_LEN [3]   = '{80, 50, 28};
	localparam int unsigned HUE_TENTHS [3] = '{4, 8, 16};

	localparam logic [STEP_W-1:0] RAMP_N [3] = '{
		STEP_W'(RAMP_LEN[0]), STEP_W'(RAMP_LEN[1]), STEP_W'(RAMP_LEN[2])
	};

	localparam logic [WAIT_W-1:0] BREATHE_WAIT [3] = '{8'd17, 8'd11, 8'd6};
	localparam logic [WAIT_W-1:0] HUE_WAIT [3]     = '{8'd19, 8'd13, 8'd7};
	localparam logic [WAIT_W-1:0] DARK_WAIT        = 8'd239;

	localparam int unsigned INTEN_ENTRIES = RAMP_LEN[0] + RAMP_LEN[1] + RAMP_LEN[2] + 3;
	localparam int unsigned INTEN_IDX_W   = $clog2(INTEN_ENTRIES);

	localparam int unsigned RAMP_OFFS [3] = '{
		0, RAMP_LEN[0] + 1, RAMP_LEN[0] + RAMP_LEN[1] + 2
	};

	localparam logic [INTEN_IDX_W-1:0] RAMP_BASE [3] = '{
		INTEN_IDX_W'(RAMP_OFFS[0]), INTEN_IDX_W'(RAMP_OFFS[1]),
		INTEN_IDX_W'(RAMP_OFFS[2])
	};

	localparam logic [H6_W-1:0] SECT_BASE [6] = '{
		H6_W'(0), H6_W'(HUE_UNITS_PER_TURN), H6_W'(2 * HUE_UNITS_PER_TURN),
		H6_W'(3 * HUE_UNITS_PER_TURN), H6_W'(4 * HUE_UNITS_PER_TURN),
		H6_W'(5 * HUE_UNITS_PER_TURN)
	};

	// Odd polynomial quarter sine in Q30, rounded to Q1.15.
	function automatic logic [Q15_W-1:0] sine_q15(longint unsigned idx);
		longint unsigned u, u2, u3, u5, u7, u9, pos, neg, q, i;
		i   = (idx > SINE_TABLE_DEPTH) ? longint'(SINE_TABLE_DEPTH) : idx;
		u   = (i << 30) / SINE_TABLE_DEPTH;
		u2  = (u * u) >> 30;
		u3  = (u2 * u) >> 30;
		u5  = (u3 * u2) >> 30;
		u7  = (u5 * u2) >> 30;
		u9  = (u7 * u2) >> 30;
		pos = ((64'd1686629713 * u) >> 30) + ((64'd85569305 * u5) >> 30)
			+ ((64'd172272 * u9) >> 30);
		neg = ((64'd693598668 * u3) >> 30) + ((64'd5026995 * u7) >> 30);
		q   = (pos > neg) ? pos - neg : 64'd0;
		q   = (q + 64'd16384) >> 15;
		if (q > 64'd32768) begin
			q = 64'd32768;
		end
		return Q15_W'(q);
	endfunction

	typedef logic [Q15_W-1:0] inten_tab_t [INTEN_ENTRIES];

	function automatic inten_tab_t build_inten_tab();
		inten_tab_t      tab;
		longint unsigned idx;
		for (int s = 0; s < 3; s++) begin
			for (int st = 0; st <= int'(RAMP_LEN[s]); st++) begin
				idx = longint'(st) * SINE_TABLE_DEPTH / RAMP_LEN[s];
				tab[RAMP_OFFS[s] + st] = sine_q15(idx);
			end
		end
		return tab;
	endfunction

	localparam inten_tab_t INTEN_TAB = build_inten_tab();

	function automatic logic [HUE_W-1:0] hue_step_f(int unsigned s);
		int unsigned v;
		v = HUE_UNITS_PER_TURN * HUE_TENTHS[s] / 3600;
		if (v == 0) begin
			v = 1;
		end
		return HUE_W'(v);
	endfunction

	localparam logic [HUE_W-1:0] HUE_STEP [3] = '{
		hue_step_f(0), hue_step_f(1), hue_step_f(2)
	};

endpackage

[rtl/core/rgbfx_calc.sv]
module rgbfx_calc (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rgbfx_pkg::calc_req_t          req,
	input  logic [rgbfx_pkg::Q15_W-1:0]   inten,
	input  logic [rgbfx_pkg::Q15_W-1:0]   bright,
	input  logic [rgbfx_pkg::HUE_W-1:0]   hue,
	input  logic [rgbfx_pkg::CH_W-1:0]    base_red,
	input  logic [rgbfx_pkg::CH_W-1:0]    base_green,
	input  logic [rgbfx_pkg::CH_W-1:0]    base_blue,
	output rgbfx_pkg::calc_rsp_t          rsp
);
	import rgbfx_pkg::*;

	calc_state_t state_q, state_d;
	calc_kind_t  kind_q;

	logic [MUL_P_W-1:0] prod_q;
	logic [1:0]         ch_q;
	logic [CH_W-1:0]    red_q, green_q, blue_q;
	logic [2:0]         sector_q;
	logic [HUE_W-1:0]   f_q;
	logic               pass_q;
	logic [CH_W-1:0]    up_q, dn_q;

	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] mul_p;
	logic [CH_W-1:0]    base_sel;
	logic [CH_W-1:0]    ch_val;
	logic [T_W-1:0]     tval;
	logic [CH_W-1:0]    c_val;
	logic [HUE_W-1:0]   f_cmp;
	logic [H6_W-1:0]    h6;
	logic [2:0]         sect;
	logic [HUE_W-1:0]   f_val;
	logic [CH_W-1:0]    quo;
	logic [CH_W-1:0]    r_o, g_o, b_o;

	// shared multiplier
	assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
	assign ch_val = mul_p[SCALE_SHIFT +: CH_W];
	assign quo    = mul_p[HUE_RECIP_SHIFT +: CH_W];

	assign tval  = (T_W'(bright) << 8) - T_W'(bright);
	assign c_val = tval[15 +: CH_W];
	assign f_cmp = HUE_W'(HUE_UNITS_PER_TURN) - f_q;

	assign h6 = (H6_W'(hue) << 2) + (H6_W'(hue) << 1);

	always_comb begin
		sect = 3'd0;
		for (int k = 1; k < 6; k++) begin
			if (h6 >= H6_W'(k * HUE_UNITS_PER_TURN)) begin
				sect = 3'(k);
			end
		end
	end

	assign f_val = HUE_W'(h6 - SECT_BASE[sect]);

	always_comb begin
		unique case (ch_q)
			2'd0:    base_sel = base_red;
			2'd1:    base_sel = base_green;
			default: base_sel = base_blue;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			C_IDLE: begin
				if (req.start) begin
					state_d = (req.kind == CK_HUE) ? C_HUE_SECT : C_SCALE_P;
				end
			end
			C_SCALE_P:  state_d = C_SCALE_CH;
			C_SCALE_CH: begin
				if (ch_q == 2'd2) begin
					state_d = C_DONE;
				end
			end
			C_HUE_SECT: state_d = C_HUE_MUL;
			C_HUE_MUL:  state_d = C_HUE_DIV;
			C_HUE_DIV:  state_d = pass_q ? C_DONE : C_HUE_MUL;
			C_DONE:     state_d = C_IDLE;
			default:    state_d = C_IDLE;
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			C_SCALE_P: begin
				mul_a = MUL_A_W'(inten);
				mul_b = bright;
			end
			C_SCALE_CH: begin
				mul_a = prod_q[MUL_A_W-1:0];
				mul_b = MUL_B_W'(base_sel);
			end
			C_HUE_MUL: begin
				mul_a = MUL_A_W'(tval);
				mul_b = MUL_B_W'(pass_q ? f_cmp : f_q);
			end
			C_HUE_DIV: begin
				mul_a = MUL_A_W'(HUE_RECIP);
				mul_b = prod_q[HUE_PRE_SHIFT +: MUL_B_W];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		r_o = '0;
		g_o = '0;
		b_o = '0;
		if (kind_q == CK_SCALE) begin
			r_o = red_q;
			g_o = green_q;
			b_o = blue_q;
		end else begin
			unique case (sector_q)
				3'd0: begin r_o = c_val; g_o = up_q; end
				3'd1: begin r_o = dn_q;  g_o = c_val; end
				3'd2: begin g_o = c_val; b_o = up_q; end
				3'd3: begin g_o = dn_q;  b_o = c_val; end
				3'd4: begin r_o = up_q;  b_o = c_val; end
				default: begin r_o = c_val; b_o = dn_q; end
			endcase
		end
	end

	assign rsp.done   = (state_q == C_DONE);
	assign rsp.colour = {r_o, g_o, b_o};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			C_IDLE: begin
				if (req.start) begin
					kind_q <= req.kind;
					ch_q   <= 2'd0;
				end
			end
			C_SCALE_P: prod_q <= mul_p;
			C_SCALE_CH: begin
				unique case (ch_q)
					2'd0:    red_q   <= ch_val;
					2'd1:    green_q <= ch_val;
					default: blue_q  <= ch_val;
				endcase
				ch_q <= ch_q + 2'd1;
			end
			C_HUE_SECT: begin
				sector_q <= sect;
				f_q      <= f_val;
				pass_q   <= 1'b0;
			end
			C_HUE_MUL: prod_q <= mul_p;
			C_HUE_DIV: begin
				if (pass_q) begin
					dn_q <= quo;
				end else begin
					up_q <= quo;
				end
				pass_q <= 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

[rtl/core/rgb_led_effect_generator.sv]
// channel | dir | fields (low bit first)              | transfer when
// s_      | in  | tdata: restart                      | s_tvalid & s_tready
// m_      | out | tdata: red, green, blue; tuser: frame_sent | m_tvalid & m_tready
// cfg_    | in  | cfg_index, cfg_data                 | cfg_wen
// One tick at a time: the next tick waits until the last result is taken on m_, and the one
// shared multiplier is reused for each product and reciprocal quotient of a colour.
// arst_n restores register defaults, idle phase and black held colour.
// A finished result holds on m_ until taken; s_tready stays low until then.
module rgb_led_effect_generator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // restart
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [rgbfx_pkg::COLOUR_W-1:0]  m_tdata,   // red, green, blue
	output logic                            m_tuser,   // frame_sent
	input  logic                            cfg_wen,
	input  logic [rgbfx_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rgbfx_pkg::REG_W-1:0]     cfg_data
);
	import rgbfx_pkg::*;

	logic [CH_W-1:0] base_red_q, base_green_q, base_blue_q;
	mode_t           mode_q;
	logic [1:0]      speed_q;
	logic [1:0]      bright_q;

	top_state_t          state_q, state_d;
	phase_t              phase_q;
	logic [STEP_W-1:0]   ramp_q;
	logic [WAIT_W-1:0]   wait_q;
	logic [HUE_W-1:0]    hue_q;
	logic [COLOUR_W-1:0] held_q;
	logic                frame_q;
	logic [Q15_W-1:0]    inten_q;
	logic [HUE_W-1:0]    huearg_q;

	logic                accept;
	logic                restart;
	logic [1:0]          sp;
	phase_t              ph_d;
	logic [STEP_W-1:0]   ramp_d;
	logic [STEP_W-1:0]   rc;
	logic [STEP_W-1:0]   n_steps;
	logic [WAIT_W-1:0]   wait_d;
	logic [HUE_W-1:0]    hue_d;
	logic [HUE_W-1:0]    hc;
	logic [HUE_SUM_W-1:0] hsum;
	logic [Q15_W-1:0]    inten_d;
	logic [HUE_W-1:0]    huearg_d;
	act_t                act;
	logic                frame_d;
	logic                compute;
	calc_req_t           req;
	calc_rsp_t           rsp;

	assign restart = s_tdata[0];
	assign accept  = s_tvalid && s_tready;
	assign sp      = (speed_q > 2'd2) ? 2'd2 : speed_q;
	assign n_steps = RAMP_N[sp];
	assign compute = (act == ACT_SCALE) || (act == ACT_HUE);

	always_comb begin
		ph_d     = phase_q;
		ramp_d   = ramp_q;
		wait_d   = wait_q;
		hue_d    = hue_q;
		act      = ACT_NONE;
		frame_d  = 1'b0;
		inten_d  = Q15_ONE;
		huearg_d = hue_q;
		rc       = (ramp_q > n_steps) ? n_steps : ramp_q;
		hc       = (hue_q >= HUE_W'(HUE_UNITS_PER_TURN)) ? '0 : hue_q;
		hsum     = HUE_SUM_W'(hc) + HUE_SUM_W'(HUE_STEP[sp]);
		if (restart) begin
			ramp_d = '0;
			wait_d = '0;
			hue_d  = '0;
			ph_d   = PH_IDLE;
			rc     = '0;
			hc     = '0;
			hsum   = HUE_SUM_W'(HUE_STEP[sp]);
			unique case (mode_q)
				FX_SOLID: begin
					act     = ACT_SCALE;
					frame_d = 1'b1;
				end
				FX_DARK: begin
					act     = ACT_BLACK;
					frame_d = 1'b1;
				end
				default: ph_d = PH_RISE;
			endcase
		end
		if (!frame_d) begin
			if ((mode_q == FX_SOLID) || (mode_q == FX_DARK)) begin
				ph_d = PH_IDLE;
			end else if (ph_d != PH_IDLE) begin
				if (wait_d != '0) begin
					wait_d = wait_d - 1'b1;
				end else if (mode_q == FX_PULSE) begin
					if (ph_d == PH_PAUSE) begin
						ph_d   = PH_RISE;
						ramp_d = '0;
						wait_d = DARK_WAIT;
					end else begin
						inten_d = INTEN_TAB[RAMP_BASE[sp] + INTEN_IDX_W'(rc)];
						act     = ACT_SCALE;
						frame_d = 1'b1;
						ramp_d  = rc;
						if (ph_d == PH_RISE) begin
							if (rc == n_steps) begin
								ph_d = PH_FALL;
							end else begin
								ramp_d = rc + 1'b1;
							end
						end else if (rc == '0) begin
							ph_d = PH_PAUSE;
						end else begin
							ramp_d = rc - 1'b1;
						end
						wait_d = BREATHE_WAIT[sp];
					end
				end else begin
					huearg_d = hc;
					act      = ACT_HUE;
					frame_d  = 1'b1;
					if (hsum >= HUE_SUM_W'(HUE_UNITS_PER_TURN)) begin
						hue_d = HUE_W'(hsum - HUE_SUM_W'(HUE_UNITS_PER_TURN));
					end else begin
						hue_d = hsum[HUE_W-1:0];
					end
					wait_d = HUE_WAIT[sp];
				end
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			T_IDLE: begin
				if (s_tvalid) begin
					state_d = compute ? T_CALC : T_OUT;
				end
			end
			T_CALC: begin
				if (rsp.done) begin
					state_d = T_OUT;
				end
			end
			T_OUT: begin
				if (m_tready) begin
					state_d = T_IDLE;
				end
			end
			default: state_d = T_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = (state_q == T_IDLE);
		m_tvalid  = (state_q == T_OUT);
		req.start = accept && compute;
		req.kind  = (act == ACT_HUE) ? CK_HUE : CK_SCALE;
	end

	assign m_tdata = {held_q[CH_W-1:0], held_q[CH_W +: CH_W], held_q[2*CH_W +: CH_W]};
	assign m_tuser = frame_q;

	rgbfx_calc u_calc (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.inten      (inten_q),
		.bright     (BRIGHT_Q15[bright_q]),
		.hue        (huearg_q),
		.base_red   (base_red_q),
		.base_green (base_green_q),
		.base_blue  (base_blue_q),
		.rsp        (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_red_q   <= 8'd255;
			base_green_q <= 8'd255;
			base_blue_q  <= 8'd255;
			mode_q       <= FX_SOLID;
			speed_q      <= 2'd1;
			bright_q     <= 2'd3;
		end else if (cfg_wen) begin
			unique case (reg_idx_t'(cfg_index))
				REG_BASE_RED:   base_red_q   <= cfg_data[CH_W-1:0];
				REG_BASE_GREEN: base_green_q <= cfg_data[CH_W-1:0];
				REG_BASE_BLUE:  base_blue_q  <= cfg_data[CH_W-1:0];
				REG_MODE:       mode_q       <= mode_t'(cfg_data[1:0]);
				REG_SPEED:      speed_q      <= cfg_data[1:0];
				REG_BRIGHTNESS: bright_q     <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			phase_q <= PH_IDLE;
			ramp_q  <= '0;
			wait_q  <= '0;
			hue_q   <= '0;
			held_q  <= '0;
			frame_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				phase_q <= ph_d;
				ramp_q  <= ramp_d;
				wait_q  <= wait_d;
				hue_q   <= hue_d;
				frame_q <= frame_d;
				if (act == ACT_BLACK) begin
					held_q <= '0;
				end
			end
			if ((state_q == T_CALC) && rsp.done) begin
				held_q <= rsp.colour;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			inten_q  <= inten_d;
			huearg_q <= huearg_d;
		end
	end

endmodule

[rtl/core/rgbfx_checker.sv]
`include "rgb_led_effect_generator_macros.svh"

module rgbfx_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tuser
);

	`RGBFX_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
	`RGBFX_ASSERT_NOW(a_no_take_while_out, clk, arst_n, m_tvalid, !s_tready, "input taken while result pending")
	`RGBFX_ASSERT_NEXT(a_busy_after_take, clk, arst_n, s_tvalid && s_tready, !s_tready, "second input taken back to back")
	`RGBFX_ASSERT_NEXT(a_one_result, clk, arst_n, m_tvalid && m_tready, !m_tvalid, "result repeated")

endmodule

bind rgb_led_effect_generator rgbfx_checker u_rgbfx_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
